FILE: rtl/core/mpq_pkg.sv
package mpq_pkg;

    typedef logic [1:0] status_t;

    localparam status_t STAT_OK    = 2'd0;
    localparam status_t STAT_EMPTY = 2'd1;
    localparam status_t STAT_FULL  = 2'd2;

    typedef logic func_t;

    localparam func_t FUNC_INSERT  = 1'b0;
    localparam func_t FUNC_EXTRACT = 1'b1;

endpackage

FILE: rtl/core/mpq_mem.sv
module mpq_mem #(
    parameter int DEPTH = 64,
    parameter int DW    = 32,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr_a,
    input  logic [AW-1:0] raddr_b,
    output logic [DW-1:0] rdata_a,
    output logic [DW-1:0] rdata_b
);

    // contents undefined until written; only live entries are ever used
    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

FILE: rtl/core/mpq_ctrl.sv
module mpq_ctrl #(
    parameter int DEPTH    = 64,
    parameter int KEY_BITS = 16,
    parameter int TAG_BITS = 16,
    localparam int AW      = $clog2(DEPTH),
    localparam int CW      = $clog2(DEPTH + 1),
    localparam int DW      = KEY_BITS + TAG_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // item side
    input  logic                  in_valid,
    output logic                  in_ready,
    input  mpq_pkg::func_t        in_func,
    input  logic [KEY_BITS-1:0]   in_key,
    input  logic [TAG_BITS-1:0]   in_tag,
    // result side
    output logic                  res_valid,
    input  logic                  res_ready,
    output mpq_pkg::status_t      res_status,
    output logic [KEY_BITS-1:0]   res_out_key,
    output logic [TAG_BITS-1:0]   res_out_tag,
    output logic [KEY_BITS-1:0]   res_top_key,
    output logic [TAG_BITS-1:0]   res_top_tag,
    output logic [CW-1:0]         res_count,
    // heap storage
    output logic                  mem_we,
    output logic [AW-1:0]         mem_waddr,
    output logic [DW-1:0]         mem_wdata,
    output logic [AW-1:0]         mem_raddr_a,
    output logic [AW-1:0]         mem_raddr_b,
    input  logic [DW-1:0]         mem_rdata_a,
    input  logic [DW-1:0]         mem_rdata_b
);

    import mpq_pkg::*;

    localparam int IW = AW + 2;
    localparam logic [CW-1:0] COUNT_FULL = CW'(DEPTH);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EX_LD  = 3'd1;
    localparam logic [2:0] ST_UP_RD  = 3'd2;
    localparam logic [2:0] ST_UP_CMP = 3'd3;
    localparam logic [2:0] ST_DN_RD  = 3'd4;
    localparam logic [2:0] ST_DN_CMP = 3'd5;
    localparam logic [2:0] ST_FIN    = 3'd6;

    logic [2:0]          state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [AW-1:0]       hole_reg, hole_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [TAG_BITS-1:0] tag_reg, tag_next;
    logic [KEY_BITS-1:0] root_key_reg, root_key_next;
    logic [TAG_BITS-1:0] root_tag_reg, root_tag_next;
    status_t             status_reg, status_next;
    logic [KEY_BITS-1:0] ok_reg, ok_next;
    logic [TAG_BITS-1:0] ot_reg, ot_next;

    logic [AW-1:0]       parent_idx;
    logic [IW-1:0]       left_idx, right_idx, n_ext;
    logic [CW-1:0]       count_dec;
    logic [KEY_BITS-1:0] rd_key_a, rd_key_b, big_key;
    logic                left_ok, right_ok, take_left, take_right;

    assign parent_idx = (hole_reg - AW'(1)) >> 1;
    assign left_idx   = (IW'(hole_reg) << 1) + IW'(1);
    assign right_idx  = (IW'(hole_reg) << 1) + IW'(2);
    assign n_ext      = IW'(count_reg);
    assign count_dec  = count_reg - CW'(1);
    assign rd_key_a   = mem_rdata_a[KEY_BITS-1:0];
    assign rd_key_b   = mem_rdata_b[KEY_BITS-1:0];

    // compare unit for one level of sift-down
    assign left_ok    = left_idx < n_ext;
    assign right_ok   = right_idx < n_ext;
    assign take_left  = left_ok && (rd_key_a > key_reg);
    assign big_key    = take_left ? rd_key_a : key_reg;
    assign take_right = right_ok && (rd_key_b > big_key);

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        hole_next     = hole_reg;
        key_next      = key_reg;
        tag_next      = tag_reg;
        root_key_next = root_key_reg;
        root_tag_next = root_tag_reg;
        status_next   = status_reg;
        ok_next       = ok_reg;
        ot_next       = ot_reg;
        mem_we        = 1'b0;
        mem_waddr     = hole_reg;
        mem_wdata     = {tag_reg, key_reg};
        mem_raddr_a   = parent_idx;
        mem_raddr_b   = right_idx[AW-1:0];

        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    key_next    = in_key;
                    tag_next    = in_tag;
                    status_next = STAT_OK;
                    ok_next     = '0;
                    ot_next     = '0;
                    if (in_func == FUNC_INSERT) begin
                        if (count_reg >= COUNT_FULL) begin
                            status_next = STAT_FULL;
                            state_next  = ST_FIN;
                        end else begin
                            hole_next  = count_reg[AW-1:0];
                            count_next = count_reg + CW'(1);
                            state_next = ST_UP_RD;
                        end
                    end else begin
                        if (count_reg == '0) begin
                            status_next = STAT_EMPTY;
                            state_next  = ST_FIN;
                        end else begin
                            // root comes from the mirror; fetch the last entry
                            ok_next     = root_key_reg;
                            ot_next     = root_tag_reg;
                            count_next  = count_dec;
                            mem_raddr_a = count_dec[AW-1:0];
                            state_next  = ST_EX_LD;
                        end
                    end
                end
            end
            ST_EX_LD: begin
                key_next = rd_key_a;
                tag_next = mem_rdata_a[DW-1:KEY_BITS];
                if (count_reg == '0) begin
                    state_next = ST_FIN;
                end else begin
                    hole_next  = '0;
                    state_next = ST_DN_RD;
                end
            end
            ST_UP_RD: begin
                if (hole_reg == '0) begin
                    mem_we     = 1'b1;
                    state_next = ST_FIN;
                end else begin
                    state_next = ST_UP_CMP;
                end
            end
            ST_UP_CMP: begin
                mem_we = 1'b1;
                if (rd_key_a < key_reg) begin
                    mem_wdata  = mem_rdata_a;
                    hole_next  = parent_idx;
                    state_next = ST_UP_RD;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_DN_RD: begin
                mem_raddr_a = left_idx[AW-1:0];
                mem_raddr_b = right_idx[AW-1:0];
                state_next  = ST_DN_CMP;
            end
            ST_DN_CMP: begin
                mem_we = 1'b1;
                if (take_right) begin
                    mem_wdata  = mem_rdata_b;
                    hole_next  = right_idx[AW-1:0];
                    state_next = ST_DN_RD;
                end else if (take_left) begin
                    mem_wdata  = mem_rdata_a;
                    hole_next  = left_idx[AW-1:0];
                    state_next = ST_DN_RD;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // keep a copy of the root so top and extract need no read
        if (mem_we && (mem_waddr == '0)) begin
            root_key_next = mem_wdata[KEY_BITS-1:0];
            root_tag_next = mem_wdata[DW-1:KEY_BITS];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        hole_reg     <= hole_next;
        key_reg      <= key_next;
        tag_reg      <= tag_next;
        root_key_reg <= root_key_next;
        root_tag_reg <= root_tag_next;
        status_reg   <= status_next;
        ok_reg       <= ok_next;
        ot_reg       <= ot_next;
    end

    assign in_ready    = (state_reg == ST_IDLE);
    assign res_valid   = (state_reg == ST_FIN);
    assign res_status  = status_reg;
    assign res_out_key = ok_reg;
    assign res_out_tag = ot_reg;
    assign res_top_key = (count_reg != '0) ? root_key_reg : '0;
    assign res_top_tag = (count_reg != '0) ? root_tag_reg : '0;
    assign res_count   = count_reg;

endmodule

FILE: rtl/core/max_priority_queue_unit.sv
// Binary max-heap priority queue of key/tag pairs.
// An insert writes the new entry at the end and climbs it one level per read/compare step
//   until its parent is not smaller; an extract returns the root, moves the last entry to the
//   root and sifts it down one level per read/compare step; a refused word goes to the result.
// One word at a time: a new word is taken once the last result has reached the output register.
// Reset (aresetn low, synchronous): heap empty, sequencer idle, output invalid.
module max_priority_queue_unit #(
    parameter int DEPTH    = 64,
    parameter int KEY_BITS = 16,
    parameter int TAG_BITS = 16,
    localparam int CW      = $clog2(DEPTH + 1),
    localparam int IN_W    = KEY_BITS + TAG_BITS,
    localparam int IN_TW   = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W   = 2 * KEY_BITS + 2 * TAG_BITS + CW + 1,
    localparam int OUT_TW  = ((OUT_W + 7) / 8) * 8
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // input words
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [IN_TW-1:0]        s_tdata,   // item_key, item_tag, zero pad
    input  mpq_pkg::func_t          s_tuser,   // func
    // result words
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [OUT_TW-1:0]       m_tdata,   // out_key, out_tag, top_key, top_tag,
                                               // count, is_empty, zero pad
    output mpq_pkg::status_t        m_tuser    // status
);

    import mpq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int DW = KEY_BITS + TAG_BITS;

    // sequencer <-> result register
    logic                res_valid, res_ready;
    status_t             res_status;
    logic [KEY_BITS-1:0] res_out_key, res_top_key;
    logic [TAG_BITS-1:0] res_out_tag, res_top_tag;
    logic [CW-1:0]       res_count;

    // heap memory port
    logic                mem_we;
    logic [AW-1:0]       mem_waddr, mem_raddr_a, mem_raddr_b;
    logic [DW-1:0]       mem_wdata, mem_rdata_a, mem_rdata_b;

    // output register
    logic                m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]    m_data_reg;
    status_t             m_status_reg;

    mpq_ctrl #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS),
        .TAG_BITS (TAG_BITS)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_func     (s_tuser),
        .in_key      (s_tdata[KEY_BITS-1:0]),
        .in_tag      (s_tdata[IN_W-1:KEY_BITS]),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_status  (res_status),
        .res_out_key (res_out_key),
        .res_out_tag (res_out_tag),
        .res_top_key (res_top_key),
        .res_top_tag (res_top_tag),
        .res_count   (res_count),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_raddr_a (mem_raddr_a),
        .mem_raddr_b (mem_raddr_b),
        .mem_rdata_a (mem_rdata_a),
        .mem_rdata_b (mem_rdata_b)
    );

    mpq_mem #(
        .DEPTH (DEPTH),
        .DW    (DW)
    ) u_mem (
        .aclk    (aclk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .raddr_a (mem_raddr_a),
        .raddr_b (mem_raddr_b),
        .rdata_a (mem_rdata_a),
        .rdata_b (mem_rdata_b)
    );

    // register takes a new result when empty or being drained
    assign res_ready = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_ready) begin
            m_valid_next = res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        if (res_valid && res_ready) begin
            m_status_reg <= res_status;
            m_data_reg   <= {(res_count == '0), res_count, res_top_tag, res_top_key,
                             res_out_tag, res_out_key};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = OUT_TW'(m_data_reg);

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

// Stream-level check of the max-heap priority queue: every accepted input word
// is run through a behavioral heap kept here, and each result word is compared
// field by field against the oldest prediction.
module tb_top;
    import mpq_pkg::*;

    localparam int DEPTH          = 64;
    localparam int KEY_BITS       = 16;
    localparam int TAG_BITS       = 16;
    localparam int CW             = $clog2(DEPTH + 1);
    localparam int IN_TW          = 32;
    localparam int OUT_TW         = 72;
    localparam int RANDOM_WORDS   = 650;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TAIL_CYCLES    = 40;
    localparam int MAX_PRINTED    = 30;

    typedef struct {
        func_t               func;
        logic [KEY_BITS-1:0] key;
        logic [TAG_BITS-1:0] tag;
        bit                  drain;   // hold this word until all results are back
    } heap_cmd_t;

    typedef struct packed {
        status_t             status;
        logic [KEY_BITS-1:0] out_key;
        logic [TAG_BITS-1:0] out_tag;
        logic [KEY_BITS-1:0] top_key;
        logic [TAG_BITS-1:0] top_tag;
        logic [CW-1:0]       count;
        logic                is_empty;
    } heap_result_t;

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_TW-1:0]  s_tdata;
    func_t             s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_TW-1:0] m_tdata;
    status_t           m_tuser;

    max_priority_queue_unit #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS),
        .TAG_BITS (TAG_BITS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    heap_cmd_t    cmd_q[$];       // words waiting to be sent
    heap_result_t pending_res_q[$]; // predicted results, oldest first
    int           total_words;
    int           sent_words;
    int           err_count;
    int           idle_cycles;
    bit           run_done;

    // Shadow heap state
    logic [KEY_BITS-1:0] heap_key[DEPTH];
    logic [TAG_BITS-1:0] heap_tag[DEPTH];
    int unsigned         heap_fill;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic void swap_slots(int unsigned a, int unsigned b);
        logic [KEY_BITS-1:0] k;
        logic [TAG_BITS-1:0] t;
        k = heap_key[a];
        t = heap_tag[a];
        heap_key[a] = heap_key[b];
        heap_tag[a] = heap_tag[b];
        heap_key[b] = k;
        heap_tag[b] = t;
    endfunction

    // Applies one word to the shadow heap and returns the result it should produce.
    function automatic heap_result_t apply_heap_op(func_t func, logic [KEY_BITS-1:0] key,
                                                   logic [TAG_BITS-1:0] tag);
        heap_result_t r;
        int unsigned  i, p, l, rc, big;
        bit           settled;
        r = '0;
        r.status = STAT_OK;
        if (func == FUNC_INSERT) begin
            if (heap_fill >= DEPTH) begin
                r.status = STAT_FULL;
            end else begin
                i = heap_fill;
                heap_key[i] = key;
                heap_tag[i] = tag;
                settled = 1'b0;
                // climb only while the parent is strictly smaller
                while (i > 0 && !settled) begin
                    p = (i - 1) / 2;
                    if (heap_key[p] < heap_key[i]) begin
                        swap_slots(p, i);
                        i = p;
                    end else begin
                        settled = 1'b1;
                    end
                end
                heap_fill++;
            end
        end else begin
            if (heap_fill == 0) begin
                r.status = STAT_EMPTY;
            end else begin
                r.out_key = heap_key[0];
                r.out_tag = heap_tag[0];
                heap_fill--;
                heap_key[0] = heap_key[heap_fill];
                heap_tag[0] = heap_tag[heap_fill];
                i = 0;
                settled = 1'b0;
                // left child first, then right, each only on strictly greater
                while (!settled) begin
                    l = 2 * i + 1;
                    rc = 2 * i + 2;
                    big = i;
                    if (l < heap_fill && heap_key[l] > heap_key[big]) big = l;
                    if (rc < heap_fill && heap_key[rc] > heap_key[big]) big = rc;
                    if (big == i) begin
                        settled = 1'b1;
                    end else begin
                        swap_slots(i, big);
                        i = big;
                    end
                end
            end
        end
        if (heap_fill != 0) begin
            r.top_key = heap_key[0];
            r.top_tag = heap_tag[0];
        end
        r.count    = CW'(heap_fill);
        r.is_empty = (heap_fill == 0);
        return r;
    endfunction

    // Idle percentage per side: three equal phases over the run.
    function automatic int idle_pct(bit rx_side);
        int phase;
        phase = (total_words == 0) ? 0 : (sent_words * 3) / total_words;
        case (phase)
            0: begin
                return rx_side ? 71 : 36;
            end
            1: begin
                return rx_side ? 36 : 71;
            end
            default: begin
                return 0;
            end
        endcase
    endfunction

    task automatic report_mismatch(string what);
        err_count++;
        if (err_count <= MAX_PRINTED) $display("[%0t] MISMATCH %s", $time, what);
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want) report_mismatch($sformatf("%s: got %0h, want %0h", name, got, want));
    endtask

    // Driver: one NBA per signal per edge; holds the word while tready is low.
    always @(posedge aclk) begin : word_driver
        heap_cmd_t cmd;
        logic      nxt_valid;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            nxt_valid = s_tvalid;
            if (s_tvalid && s_tready) begin
                pending_res_q = {pending_res_q,
                                 apply_heap_op(s_tuser, s_tdata[KEY_BITS-1:0],
                                               s_tdata[KEY_BITS +: TAG_BITS])};
                sent_words++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && cmd_q.size() > 0) begin
                if (!(cmd_q[0].drain && pending_res_q.size() > 0) &&
                    $urandom_range(0, 99) >= idle_pct(1'b0)) begin
                    cmd = cmd_q.pop_front();
                    s_tdata   <= {cmd.tag, cmd.key};
                    s_tuser   <= cmd.func;
                    nxt_valid = 1'b1;
                end
            end
            s_tvalid <= nxt_valid;
        end
    end

    // Receiver backpressure and result check.
    always @(posedge aclk) begin : result_monitor
        heap_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= idle_pct(1'b1));
            if (m_tvalid && m_tready) begin
                if (pending_res_q.size() == 0) begin
                    report_mismatch("result word with no prediction pending");
                end else begin
                    want = pending_res_q.pop_front();
                    check_field("status",   m_tuser,                   want.status);
                    check_field("out_key",  m_tdata[15:0],             want.out_key);
                    check_field("out_tag",  m_tdata[31:16],            want.out_tag);
                    check_field("top_key",  m_tdata[47:32],            want.top_key);
                    check_field("top_tag",  m_tdata[63:48],            want.top_tag);
                    check_field("count",    m_tdata[64 +: CW],         want.count);
                    check_field("is_empty", m_tdata[64 + CW],          want.is_empty);
                end
            end
        end
    end

    // Watchdog on cycles with no handshake on either side.
    always @(posedge aclk) begin
        if (!aresetn || run_done || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Stimulus generation; track the fill level so runs can steer to full and empty.
    int gen_fill;

    task automatic add_cmd(func_t func, logic [KEY_BITS-1:0] key, logic [TAG_BITS-1:0] tag,
                           bit drain = 1'b0);
        heap_cmd_t c;
        c.func  = func;
        c.key   = key;
        c.tag   = tag;
        c.drain = drain;
        cmd_q = {cmd_q, c};
        if (func == FUNC_INSERT && gen_fill < DEPTH) gen_fill++;
        if (func == FUNC_EXTRACT && gen_fill > 0) gen_fill--;
    endtask

    function automatic logic [KEY_BITS-1:0] pick_key();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 25) return KEY_BITS'($urandom_range(0, 3));     // lots of ties
        if (sel < 35) return ($urandom_range(0, 1) != 0) ? '1 : '0;
        return KEY_BITS'($urandom);
    endfunction

    function automatic func_t pick_func(int insert_pct);
        return ($urandom_range(0, 99) < insert_pct) ? FUNC_INSERT : FUNC_EXTRACT;
    endfunction

    initial begin : stimulus
        int mode;
        int n;
        bit hold;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = FUNC_INSERT;
        m_tready    = 1'b0;
        sent_words  = 0;
        err_count   = 0;
        idle_cycles = 0;
        run_done    = 1'b0;
        heap_fill   = 0;
        gen_fill    = 0;

        // Directed: empty extract, extremes of key and tag, equal keys both ways.
        add_cmd(FUNC_EXTRACT, 16'hFFFF, 16'hFFFF);
        add_cmd(FUNC_INSERT,  16'h0000, 16'h0000);
        add_cmd(FUNC_INSERT,  16'hFFFF, 16'hFFFF);
        add_cmd(FUNC_INSERT,  16'hFFFF, 16'h1234);   // tie with root, must not climb
        add_cmd(FUNC_INSERT,  16'h8000, 16'hAAAA);
        add_cmd(FUNC_INSERT,  16'h8000, 16'h5555);
        add_cmd(FUNC_INSERT,  16'h0001, 16'h0001);
        add_cmd(FUNC_INSERT,  16'h0000, 16'hFFFF);
        add_cmd(FUNC_INSERT,  16'h7FFF, 16'h8000);
        repeat (9) add_cmd(FUNC_EXTRACT, 16'h0000, 16'h0000);
        add_cmd(FUNC_EXTRACT, 16'h5A5A, 16'hA5A5);

        // Random runs: fill to full and overflow, drain to empty and underflow, or mix.
        n = 0;
        while (n < RANDOM_WORDS) begin
            mode = $urandom_range(0, 2);
            hold = (n == 0) || ($urandom_range(0, 3) == 0);
            case (mode)
                0: begin
                    while (gen_fill < DEPTH) begin
                        add_cmd(pick_func(85), pick_key(), TAG_BITS'($urandom), hold);
                        hold = 1'b0;
                        n++;
                    end
                    repeat ($urandom_range(1, 3)) begin
                        add_cmd(FUNC_INSERT, pick_key(), TAG_BITS'($urandom));
                        n++;
                    end
                end
                1: begin
                    while (gen_fill > 0) begin
                        add_cmd(pick_func(15), pick_key(), TAG_BITS'($urandom), hold);
                        hold = 1'b0;
                        n++;
                    end
                    repeat ($urandom_range(1, 2)) begin
                        add_cmd(FUNC_EXTRACT, pick_key(), TAG_BITS'($urandom));
                        n++;
                    end
                end
                default: begin
                    repeat ($urandom_range(10, 40)) begin
                        add_cmd(pick_func(55), pick_key(), TAG_BITS'($urandom), hold);
                        hold = 1'b0;
                        n++;
                    end
                end
            endcase
        end
        total_words = cmd_q.size();

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        while (cmd_q.size() > 0 || s_tvalid || pending_res_q.size() > 0) @(posedge aclk);
        run_done = 1'b1;
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (err_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
